### rtl/core/hsl_pkg.sv
`default_nettype none

package hsl_pkg;

  // Hue circle in 1/16 degree units
  localparam int unsigned HueFull  = 5760;
  localparam int unsigned HueThird = 1920;
  localparam int unsigned HueSixth = 960;
  // Hue offset that makes every 16-bit signed hue non-negative: 6 full turns
  localparam int unsigned HueBias  = 6 * HueFull;
  // Q3.12 unit and half unit
  localparam int unsigned OneQ12   = 4096;
  localparam int unsigned HalfQ12  = OneQ12 / 2;

  // Entry handed from the front end to the back end
  typedef struct packed {
    logic        grey;      // saturation clamped to zero
    logic [7:0]  grey_lvl;  // floor(L * 255)
    logic [7:0]  alpha;
    logic [12:0] hue;       // reduced hue, 0 .. HueFull-1
    logic [12:0] light;     // clamped lightness, 0 .. OneQ12
    logic [12:0] sat;       // clamped saturation, 0 .. OneQ12
    logic [24:0] prod;      // light * sat
  } hsl_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } hsl_queue_stat_t;

  typedef struct packed {
    logic s1_valid;
    logic s2_valid;
  } hsl_back_stat_t;

  // Clamp a signed Q3.12 value to 0 .. 1.0
  function automatic logic [12:0] hsl_clamp_unit(input logic signed [15:0] v);
    logic [12:0] r;
    if (v[15]) begin
      r = '0;
    end else if (v > 16'sd4096) begin
      r = 13'(OneQ12);
    end else begin
      r = v[12:0];
    end
    return r;
  endfunction

  // Interpolation weight over HueSixth for a hue fraction over HueFull
  function automatic logic [9:0] hsl_weight(input logic [12:0] t);
    logic [9:0] k;
    if (t < 13'(HueSixth)) begin
      k = t[9:0];
    end else if (t < 13'(3 * HueSixth)) begin
      k = 10'(HueSixth);
    end else if (t < 13'(4 * HueSixth)) begin
      k = 10'(13'(4 * HueSixth) - t);
    end else begin
      k = '0;
    end
    return k;
  endfunction

endpackage

`default_nettype wire

### rtl/core/hsl_in_if.sv
`default_nettype none

interface hsl_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] hue;
  logic signed [15:0] saturation;
  logic signed [15:0] lightness;
  logic signed [15:0] opacity;

  modport source (output valid, output hue, output saturation, output lightness,
                  output opacity, input ready);
  modport sink   (input valid, input hue, input saturation, input lightness,
                  input opacity, output ready);
endinterface

`default_nettype wire

### rtl/core/hsl_out_if.sv
`default_nettype none

interface hsl_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  modport source (output valid, output red, output green, output blue,
                  output alpha, input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input alpha, output ready);
endinterface

`default_nettype wire

### rtl/core/hsl_to_rgb_converter.sv
// HSL plus opacity to 8-bit RGBA converter. Each input transaction carries
// hue (signed, 1/16 degree, any turn), saturation, lightness and opacity
// (signed Q3.12, saturation and lightness clamped to 0..1) and produces one
// output transaction with red, green and blue truncated and alpha rounded
// and clamped. Zero saturation gives grey. The block takes one transaction
// per clock while the output is not stalled and holds no state between
// transactions. A result passes through the input classification register,
// the two-entry queue and the back-end stages ahead of the output register,
// whose three 25x10 multiplier lanes set the throughput of one pixel per
// clock when the output is not stalled. A stalled output stalls the back
// end only; the queue and the front register keep accepting up to three
// more transactions.
`default_nettype none

module hsl_to_rgb_converter (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hsl_in_if.sink    in_i,
  hsl_out_if.source out_o
);
  import hsl_pkg::*;

  logic            front_valid;
  hsl_item_t       front_item;
  logic            queue_ready;
  logic            queue_valid;
  hsl_item_t       queue_item;
  logic            back_ready;
  hsl_queue_stat_t queue_stat;
  hsl_back_stat_t  back_stat;

  hsl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .hue_i        (in_i.hue),
    .saturation_i (in_i.saturation),
    .lightness_i  (in_i.lightness),
    .opacity_i    (in_i.opacity),
    .out_valid_o  (front_valid),
    .out_item_o   (front_item),
    .out_ready_i  (queue_ready)
  );

  hsl_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_item_i  (front_item),
    .push_ready_o (queue_ready),
    .pop_valid_o  (queue_valid),
    .pop_item_o   (queue_item),
    .pop_ready_i  (back_ready),
    .stat_o       (queue_stat)
  );

  hsl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (queue_valid),
    .in_item_i   (queue_item),
    .in_ready_o  (back_ready),
    .out_valid_o (out_o.valid),
    .red_o       (out_o.red),
    .green_o     (out_o.green),
    .blue_o      (out_o.blue),
    .alpha_o     (out_o.alpha),
    .out_ready_i (out_o.ready),
    .stat_o      (back_stat)
  );

  // An accepted transaction lands in the front register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> front_valid)
    else $error("front register missed an accepted transaction");

  // A queue pop enters the first back-end stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (queue_valid && back_ready) |=> back_stat.s1_valid)
    else $error("back end dropped a popped entry");

  // Queue can never look full and empty at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(queue_stat.full && queue_stat.empty))
    else $error("queue occupancy corrupt");

  // Second stage feeds the output register whenever the pipe advances
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (back_stat.s2_valid && back_ready) |=> out_o.valid)
    else $error("output register missed a result");

endmodule

`default_nettype wire

### rtl/core/hsl_front.sv
`default_nettype none

module hsl_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic signed [15:0] hue_i,
  input  wire logic signed [15:0] saturation_i,
  input  wire logic signed [15:0] lightness_i,
  input  wire logic signed [15:0] opacity_i,
  output logic                    out_valid_o,
  output hsl_pkg::hsl_item_t      out_item_o,
  input  wire logic               out_ready_i
);
  import hsl_pkg::*;

  logic        valid_q;
  hsl_item_t   item_q;
  hsl_item_t   item_d;
  logic [16:0] hue_x;
  logic [20:0] grey_x;
  logic [23:0] alpha_x;
  logic [11:0] alpha_w;
  logic [25:0] prod_x;

  always_comb begin
    item_d.sat   = hsl_clamp_unit(saturation_i);
    item_d.light = hsl_clamp_unit(lightness_i);
    item_d.grey  = (item_d.sat == '0);

    // Bias hue into 1792 .. 67327, then reduce by 8, 4, 2 and 1 full turns
    hue_x = 17'({~hue_i[15], hue_i[14:0]}) + 17'(HueBias - 32768);
    for (int i = 0; i < 4; i++) begin
      if (hue_x >= (17'(HueFull) << (3 - i))) begin
        hue_x = hue_x - (17'(HueFull) << (3 - i));
      end
    end
    item_d.hue = hue_x[12:0];

    prod_x      = 26'(item_d.sat) * 26'(item_d.light);
    item_d.prod = prod_x[24:0];

    grey_x          = {item_d.light, 8'b0} - {8'b0, item_d.light};
    item_d.grey_lvl = grey_x[19:12];

    alpha_x = ({1'b0, opacity_i[14:0], 8'b0} - {9'b0, opacity_i[14:0]})
              + 24'(HalfQ12);
    alpha_w = alpha_x[23:12];
    if (opacity_i[15] || (opacity_i == 16'sd0)) begin
      item_d.alpha = '0;
    end else if (alpha_w > 12'd255) begin
      item_d.alpha = 8'hff;
    end else begin
      item_d.alpha = alpha_w[7:0];
    end
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/hsl_queue.sv
`default_nettype none

module hsl_queue (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   push_valid_i,
  input  wire hsl_pkg::hsl_item_t     push_item_i,
  output logic                        push_ready_o,
  output logic                        pop_valid_o,
  output hsl_pkg::hsl_item_t          pop_item_o,
  input  wire logic                   pop_ready_i,
  output hsl_pkg::hsl_queue_stat_t    stat_o
);
  import hsl_pkg::*;

  hsl_item_t  entry_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  logic [1:0] count_d;
  logic       push;
  logic       pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_item_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign stat_o.full  = !push_ready_o;
  assign stat_o.empty = !pop_valid_o;

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/hsl_back.sv
`default_nettype none

module hsl_back (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire hsl_pkg::hsl_item_t   in_item_i,
  output logic                      in_ready_o,
  output logic                      out_valid_o,
  output logic [7:0]                red_o,
  output logic [7:0]                green_o,
  output logic [7:0]                blue_o,
  output logic [7:0]                alpha_o,
  input  wire logic                 out_ready_i,
  output hsl_pkg::hsl_back_stat_t   stat_o
);
  import hsl_pkg::*;

  logic en;

  // Stage 1: the lower HSL value, its difference to the upper one and the per-channel weights
  logic             s1_valid_q;
  logic [24:0]      s1_v1_q, s1_v1_d;
  logic [24:0]      s1_diff_q, s1_diff_d;
  logic [2:0][9:0]  s1_k_q, s1_k_d;
  logic             s1_grey_q;
  logic [7:0]       s1_grey_lvl_q;
  logic [7:0]       s1_alpha_q;
  logic [24:0]      v2;
  logic [25:0]      v2_hi;
  logic [25:0]      v1_x;
  logic [13:0]      t_red;
  logic [12:0]      t_blue;

  // Stage 2: channel numerators over HueSixth * 2^24
  logic             s2_valid_q;
  logic [2:0][34:0] s2_num_q, s2_num_d;
  logic             s2_grey_q;
  logic [7:0]       s2_grey_lvl_q;
  logic [7:0]       s2_alpha_q;

  // Output register
  logic             out_valid_q;
  logic [2:0][7:0]  chan_q, chan_d;
  logic [7:0]       alpha_q;
  logic [38:0]      scaled;

  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  always_comb begin
    v2_hi = {(14'(in_item_i.light) + 14'(in_item_i.sat)), 12'b0} - 26'(in_item_i.prod);
    if (in_item_i.light < 13'(HalfQ12)) begin
      v2 = {in_item_i.light, 12'b0} + in_item_i.prod;
    end else begin
      v2 = v2_hi[24:0];
    end
    v1_x      = {in_item_i.light, 13'b0} - 26'(v2);
    s1_v1_d   = v1_x[24:0];
    s1_diff_d = v2 - s1_v1_d;

    // Red is a third ahead, blue a third behind; a fraction of one stays one
    t_red = 14'(in_item_i.hue) + 14'(HueThird);
    if (t_red > 14'(HueFull)) begin
      t_red = t_red - 14'(HueFull);
    end
    if (in_item_i.hue < 13'(HueThird)) begin
      t_blue = in_item_i.hue + 13'(HueFull - HueThird);
    end else begin
      t_blue = in_item_i.hue - 13'(HueThird);
    end
    s1_k_d[0] = hsl_weight(t_red[12:0]);
    s1_k_d[1] = hsl_weight(in_item_i.hue);
    s1_k_d[2] = hsl_weight(t_blue);
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      s2_num_d[c] = ({s1_v1_q, 10'b0} - {4'b0, s1_v1_q, 6'b0})
                    + 35'(s1_diff_q) * 35'(s1_k_q[c]);
    end
  end

  // 255 / (960 * 2^24) reduces to 17 / 2^30
  always_comb begin
    scaled = '0;
    for (int c = 0; c < 3; c++) begin
      scaled = {s2_num_q[c], 4'b0} + 39'(s2_num_q[c]);
      if (s2_grey_q) begin
        chan_d[c] = s2_grey_lvl_q;
      end else if (scaled[38:30] > 9'd255) begin
        chan_d[c] = 8'hff;
      end else begin
        chan_d[c] = scaled[37:30];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_v1_q       <= s1_v1_d;
      s1_diff_q     <= s1_diff_d;
      s1_k_q        <= s1_k_d;
      s1_grey_q     <= in_item_i.grey;
      s1_grey_lvl_q <= in_item_i.grey_lvl;
      s1_alpha_q    <= in_item_i.alpha;
      s2_num_q      <= s2_num_d;
      s2_grey_q     <= s1_grey_q;
      s2_grey_lvl_q <= s1_grey_lvl_q;
      s2_alpha_q    <= s1_alpha_q;
      chan_q        <= chan_d;
      alpha_q       <= s2_alpha_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign red_o           = chan_q[0];
  assign green_o         = chan_q[1];
  assign blue_o          = chan_q[2];
  assign alpha_o         = alpha_q;
  assign stat_o.s1_valid = s1_valid_q;
  assign stat_o.s2_valid = s2_valid_q;

endmodule

`default_nettype wire
